// ===== hdl/fixed_buffer_free_list_macros.svh =====
// Assertion macros shared by the buffer free list RTL.
`ifndef FIXED_BUFFER_FREE_LIST_MACROS_SVH
`define FIXED_BUFFER_FREE_LIST_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define FBFL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("free list check failed");

// Check that cons holds in the cycle after ante.
`define FBFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("free list check failed");

`endif

// ===== hdl/fbfl_pkg.sv =====
// Shared types and constants of the buffer free list.
package fbfl_pkg;

  localparam int OFFSET_W = 26;
  localparam int BYTES_W  = 17;
  localparam int REM_W    = BYTES_W + 1;

  localparam logic [BYTES_W-1:0] DEFAULT_BUFFER_BYTES = 17'd4096;

  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_CYCLES     = OFFSET_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_EMPTY      = 2'd1,
    STATUS_BAD_OFFSET = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_BAD
  } op_e;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_CLASSIFY
  } front_state_e;

  typedef enum logic [1:0] {
    BS_INIT,
    BS_IDLE,
    BS_EXEC
  } back_state_e;

  typedef struct packed {
    logic                cmd;
    logic [OFFSET_W-1:0] free_offset;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [OFFSET_W-1:0] buffer_offset;
    logic                pool_empty;
  } rsp_t;

endpackage

// ===== hdl/fbfl_front.sv =====
// Front end: takes requests, divides free offsets by the buffer size and classifies them.
module fbfl_front #(
  parameter int NUM_BUFFERS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  fbfl_pkg::req_t                req_i,
  input  logic [fbfl_pkg::BYTES_W-1:0]  size_i,
  output logic                          busy_o,
  output logic                          push_o,
  output fbfl_pkg::op_e                 push_kind_o,
  output logic [$clog2(NUM_BUFFERS)-1:0] push_idx_o
);

  localparam int IDX_W = $clog2(NUM_BUFFERS);
  localparam logic [fbfl_pkg::OFFSET_W-1:0] NUM_LIMIT = fbfl_pkg::OFFSET_W'(NUM_BUFFERS);

  fbfl_pkg::front_state_e state_q, state_d;
  logic [fbfl_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [fbfl_pkg::OFFSET_W-1:0]  dvd_q, dvd_step;
  logic [fbfl_pkg::OFFSET_W-1:0]  quo_q, quo_step;
  logic [fbfl_pkg::REM_W-1:0]     rem_q, rem_step;
  logic                           bad_offset;

  // Restoring division, retiring DIV_RADIX_BITS quotient bits per step.
  always_comb begin
    rem_step = rem_q;
    dvd_step = dvd_q;
    quo_step = quo_q;
    for (int k = 0; k < fbfl_pkg::DIV_RADIX_BITS; k++) begin
      rem_step = {rem_step[fbfl_pkg::REM_W-2:0], dvd_step[fbfl_pkg::OFFSET_W-1]};
      dvd_step = {dvd_step[fbfl_pkg::OFFSET_W-2:0], 1'b0};
      if (rem_step >= {1'b0, size_i}) begin
        rem_step = rem_step - {1'b0, size_i};
        quo_step = {quo_step[fbfl_pkg::OFFSET_W-2:0], 1'b1};
      end else begin
        quo_step = {quo_step[fbfl_pkg::OFFSET_W-2:0], 1'b0};
      end
    end
  end

  assign bad_offset = (rem_q != '0) || (quo_q >= NUM_LIMIT);

  always_comb begin
    state_d     = state_q;
    push_o      = 1'b0;
    push_kind_o = fbfl_pkg::OP_ALLOC;
    push_idx_o  = quo_q[IDX_W-1:0];
    case (state_q)
      fbfl_pkg::FS_IDLE: begin
        if (accept_i) begin
          if (req_i.cmd == fbfl_pkg::CMD_ALLOC) begin
            push_o = 1'b1;
          end else begin
            state_d = fbfl_pkg::FS_DIV;
          end
        end
      end
      fbfl_pkg::FS_DIV: begin
        if (cnt_q == fbfl_pkg::DIV_CNT_W'(fbfl_pkg::DIV_CYCLES - 1)) begin
          state_d = fbfl_pkg::FS_CLASSIFY;
        end
      end
      fbfl_pkg::FS_CLASSIFY: begin
        push_o      = 1'b1;
        push_kind_o = bad_offset ? fbfl_pkg::OP_BAD : fbfl_pkg::OP_FREE;
        state_d     = fbfl_pkg::FS_IDLE;
      end
      default: begin
        state_d = fbfl_pkg::FS_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != fbfl_pkg::FS_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbfl_pkg::FS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == fbfl_pkg::FS_DIV) begin
        cnt_q <= cnt_q + fbfl_pkg::DIV_CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fbfl_pkg::FS_IDLE) begin
      dvd_q <= req_i.free_offset;
      rem_q <= '0;
      quo_q <= '0;
    end else if (state_q == fbfl_pkg::FS_DIV) begin
      dvd_q <= dvd_step;
      rem_q <= rem_step;
      quo_q <= quo_step;
    end
  end

endmodule

// ===== hdl/fbfl_queue.sv =====
// Short queue of classified requests between the front and back ends.
module fbfl_queue #(
  parameter int NUM_BUFFERS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  fbfl_pkg::op_e                  kind_i,
  input  logic [$clog2(NUM_BUFFERS)-1:0] idx_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output logic                           full_o,
  output fbfl_pkg::op_e                  kind_o,
  output logic [$clog2(NUM_BUFFERS)-1:0] idx_o
);

  localparam int IDX_W = $clog2(NUM_BUFFERS);

  fbfl_pkg::op_e          kind_q [fbfl_pkg::QUEUE_DEPTH];
  logic [IDX_W-1:0]       idx_q  [fbfl_pkg::QUEUE_DEPTH];
  logic [fbfl_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [fbfl_pkg::QCNT_W-1:0] count_q;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == fbfl_pkg::QCNT_W'(fbfl_pkg::QUEUE_DEPTH));
  assign kind_o  = kind_q[rd_ptr_q];
  assign idx_o   = idx_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + fbfl_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + fbfl_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + fbfl_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - fbfl_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      kind_q[wr_ptr_q] <= kind_i;
      idx_q[wr_ptr_q]  <= idx_i;
    end
  end

endmodule

// ===== hdl/fbfl_back.sv =====
// Back end: next-pointer memory, head and tail registers and the result register.
module fbfl_back #(
  parameter int NUM_BUFFERS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  fbfl_pkg::op_e                  kind_i,
  input  logic [$clog2(NUM_BUFFERS)-1:0] idx_i,
  input  logic [fbfl_pkg::BYTES_W-1:0]   size_i,
  output logic                           pop_o,
  output logic                           init_o,
  output logic                           result_valid_o,
  output fbfl_pkg::rsp_t                 result_o
);

  localparam int IDX_W  = $clog2(NUM_BUFFERS);
  localparam int PROD_W = (IDX_W + fbfl_pkg::BYTES_W > fbfl_pkg::OFFSET_W) ?
                          IDX_W + fbfl_pkg::BYTES_W : fbfl_pkg::OFFSET_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);

  fbfl_pkg::back_state_e state_q, state_d;
  logic [IDX_W-1:0]  init_cnt_q;
  logic [IDX_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic              hv_q, hv_d;
  fbfl_pkg::op_e     kind_q;
  logic [IDX_W-1:0]  idx_q;
  logic [PROD_W-1:0] prod_q;
  logic [IDX_W-1:0]  rd_data_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr, mem_wdata;
  logic              rsp_valid_q, rsp_valid_d;
  fbfl_pkg::rsp_t    rsp_q, rsp_d;

  logic [IDX_W-1:0]  next_mem [NUM_BUFFERS];

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    hv_d        = hv_q;
    mem_we      = 1'b0;
    mem_waddr   = tail_q;
    mem_wdata   = idx_q;
    pop_o       = 1'b0;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    case (state_q)
      fbfl_pkg::BS_INIT: begin
        // Link every buffer to the next one.
        mem_we    = 1'b1;
        mem_waddr = init_cnt_q;
        mem_wdata = init_cnt_q + IDX_W'(1);
        if (init_cnt_q == LAST_IDX) begin
          state_d = fbfl_pkg::BS_IDLE;
        end
      end
      fbfl_pkg::BS_IDLE: begin
        if (valid_i) begin
          pop_o   = 1'b1;
          state_d = fbfl_pkg::BS_EXEC;
        end
      end
      fbfl_pkg::BS_EXEC: begin
        rsp_valid_d         = 1'b1;
        rsp_d.status        = fbfl_pkg::STATUS_OK;
        rsp_d.buffer_offset = '0;
        case (kind_q)
          fbfl_pkg::OP_ALLOC: begin
            if (!hv_q) begin
              rsp_d.status = fbfl_pkg::STATUS_EMPTY;
            end else begin
              rsp_d.buffer_offset = prod_q[fbfl_pkg::OFFSET_W-1:0];
              if (head_q == tail_q) begin
                hv_d = 1'b0;
              end else begin
                head_d = rd_data_q;
              end
            end
          end
          fbfl_pkg::OP_FREE: begin
            if (!hv_q) begin
              head_d = idx_q;
              tail_d = idx_q;
              hv_d   = 1'b1;
            end else if (idx_q != tail_q) begin
              mem_we = 1'b1;
              tail_d = idx_q;
            end
          end
          default: begin
            rsp_d.status = fbfl_pkg::STATUS_BAD_OFFSET;
          end
        endcase
        rsp_d.pool_empty = !hv_d;
        state_d          = fbfl_pkg::BS_IDLE;
      end
      default: begin
        state_d = fbfl_pkg::BS_IDLE;
      end
    endcase
  end

  assign init_o         = (state_q == fbfl_pkg::BS_INIT);
  assign result_valid_o = rsp_valid_q;
  assign result_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbfl_pkg::BS_INIT;
      init_cnt_q  <= '0;
      head_q      <= '0;
      tail_q      <= LAST_IDX;
      hv_q        <= 1'b1;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      hv_q        <= hv_d;
      rsp_valid_q <= rsp_valid_d;
      if (state_q == fbfl_pkg::BS_INIT) begin
        init_cnt_q <= init_cnt_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (pop_o) begin
      kind_q <= kind_i;
      idx_q  <= idx_i;
      prod_q <= PROD_W'(head_q) * PROD_W'(size_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      next_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= next_mem[head_q];
  end

endmodule

// ===== hdl/fixed_buffer_free_list.sv =====
// Top level of the fixed-size buffer pool with a linked free list.
//
// Pool of NUM_BUFFERS equal buffers handed out and taken back by byte offset. A request
// is taken at a clock edge where start is high and busy is low. An allocate request pops
// the head of the free list and returns index times the buffer size; a free request
// divides the offset by the buffer size and appends the index at the tail, or reports a
// bad offset when it is misaligned or beyond the pool. Each request gives exactly one
// result, shown for a single cycle with result_valid_o high; results leave in request
// order and the receiver cannot hold them off. After reset the block walks the pointer
// memory once to link every buffer, which keeps busy high until the last link is written.
// The front end passes an allocate request straight to a two-entry queue, so allocate
// requests are taken one per cycle until the queue fills; the back end carries them out
// one at a time (pointer memory read, then update) and pops no new entry before it is
// through with the last. A result is driven from the result register, after the queue
// entry and the back end's request registers. A free request keeps busy high while the
// offset division retires two quotient bits a cycle and then while it is classified; it
// then follows the same path through the queue. Write buffer_bytes only while no request
// is in flight; a size of zero acts as one.
module fixed_buffer_free_list #(
  parameter int NUM_BUFFERS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  fbfl_pkg::req_t                req_i,
  input  logic                          cfg_we_i,
  input  logic [fbfl_pkg::BYTES_W-1:0]  cfg_wdata_i,
  output logic                          result_valid_o,
  output fbfl_pkg::rsp_t                result_o
);

`include "fixed_buffer_free_list_macros.svh"

  localparam int IDX_W = $clog2(NUM_BUFFERS);

  // Effective buffer size; zero is stored as one.
  logic [fbfl_pkg::BYTES_W-1:0] size_q;

  logic             accept;
  logic             front_busy;
  logic             push;
  fbfl_pkg::op_e    push_kind;
  logic [IDX_W-1:0] push_idx;
  logic             q_valid, q_full, pop;
  fbfl_pkg::op_e    q_kind;
  logic [IDX_W-1:0] q_idx;
  logic             back_init;

  // Hold off requests while dividing or classifying, a full queue or linking the list.
  assign busy   = front_busy || q_full || back_init;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= fbfl_pkg::DEFAULT_BUFFER_BYTES;
    end else if (cfg_we_i) begin
      size_q <= (cfg_wdata_i == '0) ? fbfl_pkg::BYTES_W'(1) : cfg_wdata_i;
    end
  end

  fbfl_front #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .accept_i    (accept),
    .req_i,
    .size_i      (size_q),
    .busy_o      (front_busy),
    .push_o      (push),
    .push_kind_o (push_kind),
    .push_idx_o  (push_idx)
  );

  fbfl_queue #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .kind_i  (push_kind),
    .idx_i   (push_idx),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .kind_o  (q_kind),
    .idx_o   (q_idx)
  );

  fbfl_back #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .valid_i        (q_valid),
    .kind_i         (q_kind),
    .idx_i          (q_idx),
    .size_i         (size_q),
    .pop_o          (pop),
    .init_o         (back_init),
    .result_valid_o,
    .result_o
  );

  // The back end goes back to idle after each request, so strobes never touch.
  `FBFL_ASSERT_NEXT(a_strobe_spacing, clk_i, rst_ni, result_valid_o, !result_valid_o)
  // No request may enter while the pointer memory is being linked.
  `FBFL_ASSERT_SAME(a_busy_in_init, clk_i, rst_ni, back_init, busy)
  // An empty pool on allocate must also be flagged as empty.
  `FBFL_ASSERT_SAME(a_empty_flag, clk_i, rst_ni,
    result_valid_o && (result_o.status == fbfl_pkg::STATUS_EMPTY), result_o.pool_empty)
  // Failed requests carry no offset.
  `FBFL_ASSERT_SAME(a_zero_offset, clk_i, rst_ni,
    result_valid_o && (result_o.status != fbfl_pkg::STATUS_OK), result_o.buffer_offset == '0)

endmodule

// ===== tb/sv/fixed_buffer_free_list_tb.sv =====
// Self-checking testbench for the linked free list buffer pool.
`timescale 1ns / 1ps

module fixed_buffer_free_list_tb;

  localparam int NUM_BUFFERS    = 1024;
  localparam int IDX_W          = $clog2(NUM_BUFFERS);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_REQUESTS = 80;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          start       = 1'b0;
  logic                          busy;
  fbfl_pkg::req_t                req_drv     = '0;
  logic                          cfg_we_i    = 1'b0;
  logic [fbfl_pkg::BYTES_W-1:0]  cfg_wdata_i = fbfl_pkg::DEFAULT_BUFFER_BYTES;
  logic                          result_valid_o;
  fbfl_pkg::rsp_t                result_o;

  fixed_buffer_free_list #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_drv),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the pool: free list links, head, tail and the buffer size.
  logic [IDX_W-1:0]             link_mem [NUM_BUFFERS];
  logic [IDX_W-1:0]             pool_head;
  logic [IDX_W-1:0]             pool_tail;
  logic                         pool_has_free;
  logic [fbfl_pkg::BYTES_W-1:0] size_reg;

  fbfl_pkg::rsp_t pending_rsp [$];   // responses owed by the block, oldest first
  int unsigned    held_idx [$];      // buffers handed out and not yet returned
  bit             gaps_on = 1'b1;

  int error_count   = 0;
  int request_count = 0;
  int result_count  = 0;
  int ok_count      = 0;
  int empty_count   = 0;
  int bad_count     = 0;
  int size_writes   = 0;

  // Size used for scaling; a zero size behaves as one byte.
  function automatic logic [63:0] unit_bytes();
    return (size_reg == '0) ? 64'd1 : 64'(size_reg);
  endfunction

  // Byte offset of a buffer index, wrapped to the offset width.
  function automatic logic [fbfl_pkg::OFFSET_W-1:0] offset_of(input int unsigned idx);
    logic [63:0] prod;
    prod = 64'(idx) * unit_bytes();
    return prod[fbfl_pkg::OFFSET_W-1:0];
  endfunction

  // Advance the shadow pool by one request and return the response it owes.
  function automatic fbfl_pkg::rsp_t apply_request(input fbfl_pkg::req_t r,
                                                   output int popped);
    fbfl_pkg::rsp_t rsp;
    logic [63:0]    quot;
    logic [63:0]    rem;
    popped = -1;
    rsp = '0;
    if (r.cmd == fbfl_pkg::CMD_ALLOC) begin
      if (!pool_has_free) begin
        rsp.status = fbfl_pkg::STATUS_EMPTY;
      end else begin
        rsp.buffer_offset = offset_of(pool_head);
        popped = int'(pool_head);
        if (pool_head == pool_tail) begin
          pool_has_free = 1'b0;
        end else begin
          pool_head = link_mem[pool_head];
        end
      end
    end else begin
      quot = 64'(r.free_offset) / unit_bytes();
      rem  = 64'(r.free_offset) % unit_bytes();
      if (rem != 0 || quot >= NUM_BUFFERS) begin
        rsp.status = fbfl_pkg::STATUS_BAD_OFFSET;
      end else if (!pool_has_free) begin
        // Empty list: the returned buffer is head and tail at once.
        pool_head     = quot[IDX_W-1:0];
        pool_tail     = quot[IDX_W-1:0];
        pool_has_free = 1'b1;
      end else if (quot[IDX_W-1:0] != pool_tail) begin
        // Returning the current tail is dropped; anything else is linked on.
        link_mem[pool_tail] = quot[IDX_W-1:0];
        pool_tail           = quot[IDX_W-1:0];
      end
    end
    rsp.pool_empty = !pool_has_free;
    return rsp;
  endfunction

  // Present one request, hold it until taken, then record the owed response.
  task automatic send_request(input fbfl_pkg::req_t r);
    fbfl_pkg::rsp_t want;
    int             popped;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start   <= 1'b1;
    req_drv <= r;
    do begin
      @(posedge clk_i);
    end while (busy);
    want = apply_request(r, popped);
    pending_rsp.push_back(want);
    if (popped >= 0) held_idx.push_back(popped);
    request_count++;
    case (want.status)
      fbfl_pkg::STATUS_OK:    ok_count++;
      fbfl_pkg::STATUS_EMPTY: empty_count++;
      default:                bad_count++;
    endcase
  endtask

  // Allocate; the offset field carries noise since the block must ignore it.
  task automatic send_alloc();
    fbfl_pkg::req_t r;
    r.cmd         = fbfl_pkg::CMD_ALLOC;
    r.free_offset = fbfl_pkg::OFFSET_W'($urandom);
    send_request(r);
  endtask

  task automatic send_free(input logic [fbfl_pkg::OFFSET_W-1:0] off);
    fbfl_pkg::req_t r;
    r.cmd         = fbfl_pkg::CMD_FREE;
    r.free_offset = off;
    send_request(r);
  endtask

  // Drop start and wait until every owed response has come back.
  task automatic drain();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Write the buffer size while the block has nothing in flight.
  task automatic write_buffer_bytes(input logic [fbfl_pkg::BYTES_W-1:0] bytes);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bytes;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    size_reg     = bytes;
    size_writes++;
  endtask

  // Return a randomly chosen held buffer.
  task automatic free_held();
    int unsigned k;
    int unsigned idx;
    k   = $urandom_range(0, held_idx.size() - 1);
    idx = held_idx[k];
    held_idx.delete(k);
    send_free(offset_of(idx));
  endtask

  // Reset size: plain allocates, bad offsets, tail return and a double free.
  task automatic test_reset_size_requests();
    fbfl_pkg::req_t r;
    r.cmd         = fbfl_pkg::CMD_ALLOC;
    r.free_offset = '1;
    send_request(r);
    send_alloc();
    send_alloc();
    held_idx.delete(1);
    send_free(offset_of(1));                  // index 1 becomes the tail
    send_free(offset_of(1));                  // tail returned again: dropped
    send_free(offset_of(1) + fbfl_pkg::OFFSET_W'(1));   // misaligned
    send_free(offset_of(NUM_BUFFERS));        // one past the pool
    send_free('1);                            // all ones offset
    held_idx.delete(0);
    send_free('0);                            // index 0
    send_free(offset_of(NUM_BUFFERS - 1));    // still free: silent double free
  endtask

  // Zero size acts as one byte; then a size of 65536 bytes, whose offsets still fit.
  task automatic test_size_extremes();
    write_buffer_bytes('0);
    send_alloc();
    send_free(fbfl_pkg::OFFSET_W'(NUM_BUFFERS));        // index just past the pool
    send_free(fbfl_pkg::OFFSET_W'(NUM_BUFFERS - 1));    // current tail
    send_free(fbfl_pkg::OFFSET_W'(3));
    write_buffer_bytes(17'd65536);
    send_alloc();
    send_free(offset_of(NUM_BUFFERS - 1));
    send_free(offset_of(2) + fbfl_pkg::OFFSET_W'(1));
  endtask

  // Empty the pool, allocate a high index at the widest size so its offset wraps,
  // then refill it.
  task automatic test_drain_and_refill();
    int guard;
    // Link the buffer after the head as the tail, so two allocates empty the pool.
    send_free(offset_of(link_mem[pool_head]));
    guard = 0;
    while (pool_has_free && guard < 2 * NUM_BUFFERS) begin
      send_alloc();
      guard++;
    end
    send_alloc();                             // empty report
    send_free(offset_of(777));                // sole free buffer: head and tail
    write_buffer_bytes('1);
    send_alloc();                             // offset wraps past the field width
    send_alloc();                             // empty again
    send_free(offset_of(5) + fbfl_pkg::OFFSET_W'(7));   // bad offset into an empty pool
    send_free(offset_of(5));                  // becomes head and tail
    send_free(offset_of(5));                  // tail again: dropped
    send_alloc();
    send_alloc();
    write_buffer_bytes(17'd1);
    while (held_idx.size() != 0) free_held();
  endtask

  // Mostly matched allocate and free traffic, with double frees and noise.
  task automatic test_random_mix();
    logic [fbfl_pkg::BYTES_W-1:0] phase_bytes [7];
    int pick;
    phase_bytes[0] = 17'd4096;
    phase_bytes[1] = 17'd1;
    phase_bytes[2] = fbfl_pkg::BYTES_W'($urandom_range(2, 131071));
    phase_bytes[3] = 17'd65536;
    phase_bytes[4] = 17'd3;
    phase_bytes[5] = '1;
    phase_bytes[6] = fbfl_pkg::BYTES_W'($urandom_range(1, 300));
    for (int p = 0; p < 7; p++) begin
      write_buffer_bytes(phase_bytes[p]);
      gaps_on = (p != 6);                     // last phase runs back to back
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45 || (held_idx.size() == 0 && pick < 80)) begin
          send_alloc();
        end else if (pick < 80) begin
          free_held();
        end else if (pick < 88) begin
          send_free(offset_of($urandom_range(0, NUM_BUFFERS - 1)));
        end else if (pick < 94 && unit_bytes() > 1) begin
          send_free(offset_of($urandom_range(0, NUM_BUFFERS - 1)) +
                    fbfl_pkg::OFFSET_W'($urandom_range(1, int'(unit_bytes()) - 1)));
        end else if (pick < 97) begin
          send_free(offset_of($urandom_range(NUM_BUFFERS, 2 * NUM_BUFFERS)));
        end else begin
          send_free(fbfl_pkg::OFFSET_W'($urandom));
        end
      end
    end
  endtask

  // Compare each response against the oldest owed one.
  always @(posedge clk_i) begin
    fbfl_pkg::rsp_t want;
    if (rst_ni && result_valid_o) begin
      result_count++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response: expected none, got st=%0d off=%0d emp=%0b",
                 $time, result_o.status, result_o.buffer_offset, result_o.pool_empty);
        error_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (result_o.status !== want.status ||
            result_o.buffer_offset !== want.buffer_offset ||
            result_o.pool_empty !== want.pool_empty) begin
          $display("%0t: mismatch: expected st=%0d off=%0d emp=%0b, got st=%0d off=%0d emp=%0b",
                   $time, want.status, want.buffer_offset, want.pool_empty,
                   result_o.status, result_o.buffer_offset, result_o.pool_empty);
          error_count++;
        end
      end
    end
  end

  // End the run when nothing moves on either side for too long.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || result_valid_o) stalled = 0;
      else stalled++;
    end
    $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      link_mem[i] = IDX_W'((i + 1) % NUM_BUFFERS);
    end
    pool_head     = '0;
    pool_tail     = IDX_W'(NUM_BUFFERS - 1);
    pool_has_free = 1'b1;
    size_reg      = fbfl_pkg::DEFAULT_BUFFER_BYTES;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_size_requests();
    test_size_extremes();
    test_drain_and_refill();
    test_random_mix();

    drain();
    repeat (20) @(posedge clk_i);
    if (pending_rsp.size() != 0) error_count++;

    $display("Covered %0d requests: %0d ok, %0d empty pool, %0d bad offset; %0d responses.",
             request_count, ok_count, empty_count, bad_count, result_count);
    $display("Buffer size written %0d times, from zero up to the full register width.",
             size_writes);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
